// File: sv/wlfo_pkg.sv
// Shared constants, register indexes, command struct and sine table builder
// for the wavetable LFO. No dependencies; every file but wlfo_tick_if uses this package.
package wlfo_pkg;

    // Table and fixed-point formats
    localparam int TABLE_BITS      = 11;
    localparam int TABLE_SIZE      = 1 << TABLE_BITS;
    localparam int PHASE_FRAC_BITS = 21;
    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_BITS      = TABLE_BITS + PHASE_FRAC_BITS;
    localparam int INC_BITS        = 32;
    localparam int PHASE_SUM_BITS  = (PHASE_BITS > INC_BITS) ? PHASE_BITS : INC_BITS;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_FRAC_BITS  = 14;
    localparam int SEL_BITS        = 2;

    // Entries lie in [-S, S], so they carry one spare bit
    localparam int ENTRY_BITS      = SAMPLE_BITS + 1;
    localparam int DIFF_BITS       = SAMPLE_BITS + 2;

    // Quarter-wave sine table, entries 0 .. N/4 inclusive
    localparam int SINE_ADDR_BITS  = TABLE_BITS - 1;
    localparam int SINE_DEPTH      = TABLE_SIZE / 4 + 1;

    // Configuration port
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INC = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SEL  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNIPOLAR  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN      = 2'd3;

    localparam logic [SEL_BITS-1:0] WAVE_SAW      = 2'd0;
    localparam logic [SEL_BITS-1:0] WAVE_SINE     = 2'd1;
    localparam logic [SEL_BITS-1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [SEL_BITS-1:0] WAVE_PULSE    = 2'd3;

    localparam logic [SEL_BITS-1:0]  WAVE_SEL_RESET = WAVE_SINE;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET     = GAIN_BITS'(1 << GAIN_FRAC_BITS);

    // 2*pi in Q30
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic addr_next;    // present the following entry to the sine table
        logic load_first;   // capture the entry at the phase index
        logic load_second;  // capture the entry after it
        logic load_interp;  // interpolate and advance the phase
        logic load_result;  // map, scale, saturate into the result register
    } wlfo_cmd_t;

    typedef logic [SAMPLE_BITS-1:0] sine_mag_t;
    typedef sine_mag_t sine_rom_t [SINE_DEPTH];

    // Sine magnitude at folded index j: Q30 Taylor series up to x^15
    function automatic sine_mag_t sine_mag(int unsigned j);
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        longint      sum;
        u    = (64'(j) << 32) >> TABLE_BITS;
        x    = (u * TWO_PI_Q30) >> 32;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        mag = (64'(sum) * (64'd1 << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
        return sine_mag_t'(mag);
    endfunction

    // Build the quarter-wave table at elaboration
    function automatic sine_rom_t sine_rom_build();
        sine_rom_t rom;
        for (int j = 0; j < SINE_DEPTH; j++)
        begin
            rom[j] = sine_mag(j);
        end
        return rom;
    endfunction

endpackage

// File: sv/wlfo_tick_if.sv
// Tick request channel: valid/ready handshake with a one-bit tick payload.
// Depends on nothing.
interface wlfo_tick_if;
    logic valid;
    logic ready;
    logic sample_tick;

    modport source (output valid, output sample_tick, input ready);
    modport sink   (input valid, input sample_tick, output ready);
endinterface

// File: sv/wlfo_value_if.sv
// Result request channel: valid/ready handshake carrying one LFO sample.
// Depends on wlfo_pkg for the sample width.
interface wlfo_value_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [wlfo_pkg::SAMPLE_BITS-1:0] lfo_value;

    modport source (output valid, output lfo_value, input ready);
    modport sink   (input valid, input lfo_value, output ready);
endinterface

// File: sv/wlfo_ctrl.sv
// Sequencer for the LFO: handshakes on both channels and the step commands.
// Depends on wlfo_pkg for the command struct.
module wlfo_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_tick,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output wlfo_pkg::wlfo_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FETCH_A = 3'd1;
    localparam logic [2:0] ST_FETCH_B = 3'd2;
    localparam logic [2:0] ST_INTERP  = 3'd3;
    localparam logic [2:0] ST_GAIN    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Step through the fetch, interpolate and scale sequence
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_tick)
                begin
                    state_next = ST_FETCH_A;
                end
            end
            ST_FETCH_A:
            begin
                cmd.load_first = 1'b1;
                cmd.addr_next  = 1'b1;
                state_next     = ST_FETCH_B;
            end
            ST_FETCH_B:
            begin
                cmd.load_second = 1'b1;
                state_next      = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.load_interp = 1'b1;
                state_next      = ST_GAIN;
            end
            ST_GAIN:
            begin
                // hold until the result register can take the new sample
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/wlfo_datapath.sv
// LFO datapath: config registers, phase accumulator, sine table, waveform
// entries, interpolation, unipolar map, gain and saturation. Uses wlfo_pkg.
module wlfo_datapath
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wen,
    input  logic [wlfo_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [wlfo_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  wlfo_pkg::wlfo_cmd_t                       cmd,
    output logic signed [wlfo_pkg::SAMPLE_BITS-1:0]   result
);

    localparam int TB  = wlfo_pkg::TABLE_BITS;
    localparam int FB  = wlfo_pkg::PHASE_FRAC_BITS;
    localparam int SB  = wlfo_pkg::SAMPLE_BITS;
    localparam int EB  = wlfo_pkg::ENTRY_BITS;
    localparam int DB  = wlfo_pkg::DIFF_BITS;
    localparam int PHB = wlfo_pkg::PHASE_BITS;
    localparam int PSB = wlfo_pkg::PHASE_SUM_BITS;
    localparam int GB  = wlfo_pkg::GAIN_BITS;
    localparam int GFB = wlfo_pkg::GAIN_FRAC_BITS;
    localparam int AB  = wlfo_pkg::SINE_ADDR_BITS;
    localparam int RW  = TB + SB + 2;
    localparam int PB  = DB + FB + 1;
    localparam int GPB = EB + GB + 1;

    localparam logic signed [EB-1:0]  ONE_S    = EB'(1 << (SB - 1));
    localparam logic signed [DB-1:0]  ONE_S_D  = DB'(1 << (SB - 1));
    localparam logic signed [PB-1:0]  INT_HALF = PB'(1) <<< (FB - 1);
    localparam logic signed [GPB-1:0] G_HALF   = GPB'(1 << (GFB - 1));
    localparam logic signed [GPB-1:0] SAT_HI   = GPB'((1 << (SB - 1)) - 1);
    localparam logic signed [GPB-1:0] SAT_LO   = -SAT_HI - GPB'(1);

    localparam wlfo_pkg::sine_rom_t SINE_ROM = wlfo_pkg::sine_rom_build();

    logic [wlfo_pkg::INC_BITS-1:0]  phase_inc_reg;
    logic [wlfo_pkg::SEL_BITS-1:0]  wave_sel_reg;
    logic                           unipolar_reg;
    logic [GB-1:0]                  gain_reg;
    logic [PHB-1:0]                 phase_reg;
    logic [SB-1:0]                  rom_q_reg;
    logic signed [EB-1:0]           y1_reg;
    logic signed [EB-1:0]           y2_reg;
    logic signed [EB-1:0]           interp_reg;
    logic signed [SB-1:0]           result_reg;

    logic [PSB-1:0]                 phase_sum;
    logic [TB-1:0]                  idx;
    logic [TB-1:0]                  nxt;
    logic [FB-1:0]                  frac;
    logic [TB-1:0]                  entry_index;
    logic [AB-1:0]                  rom_addr;
    logic signed [EB-1:0]           entry;
    logic signed [DB-1:0]           diff;
    logic signed [PB-1:0]           prod;
    logic signed [PB-1:0]           prod_shift;
    logic signed [EB-1:0]           interp_next;
    logic signed [DB-1:0]           uni_sum;
    logic signed [EB-1:0]           mapped;
    logic signed [GPB-1:0]          gain_prod;
    logic signed [GPB-1:0]          gain_shift;
    logic signed [SB-1:0]           result_next;

    // Fold a table index onto the quarter wave
    function automatic logic [AB-1:0] sine_fold(logic [TB-1:0] i);
        logic [TB-1:0] j;
        j = {1'b0, i[TB-2:0]};
        if (j > TB'(wlfo_pkg::TABLE_SIZE / 4))
        begin
            j = TB'(wlfo_pkg::TABLE_SIZE / 2) - j;
        end
        return j[AB-1:0];
    endfunction

    // Waveform entry at index i; mag is the sine table word for i
    function automatic logic signed [EB-1:0] shape_entry(
        logic [wlfo_pkg::SEL_BITS-1:0] sel,
        logic [TB-1:0]                 i,
        logic [SB-1:0]                 mag
    );
        logic [RW-1:0]        ramp2;
        logic [RW-1:0]        ramp4;
        logic                 first_half;
        logic signed [DB-1:0] tri_val;
        logic signed [EB-1:0] m;
        logic signed [EB-1:0] e;
        ramp2      = (RW'(i) << SB) >> TB;
        ramp4      = (RW'(i) << (SB + 1)) >> TB;
        first_half = (RW'(i) <= RW'(wlfo_pkg::TABLE_SIZE / 2));
        m          = $signed({1'b0, mag});
        if (first_half)
        begin
            tri_val = $signed({1'b0, ramp4[SB:0]}) - ONE_S_D;
        end
        else
        begin
            tri_val = DB'(3) * ONE_S_D - $signed({1'b0, ramp4[SB:0]});
        end
        case (sel)
            wlfo_pkg::WAVE_SAW:      e = $signed(ramp2[EB-1:0]) - ONE_S;
            wlfo_pkg::WAVE_SINE:     e = i[TB-1] ? -m : m;
            wlfo_pkg::WAVE_TRIANGLE: e = tri_val[EB-1:0];
            wlfo_pkg::WAVE_PULSE:    e = first_half ? ONE_S : '0;
            default:                 e = '0;
        endcase
        return e;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= '0;
            wave_sel_reg  <= wlfo_pkg::WAVE_SEL_RESET;
            unipolar_reg  <= 1'b0;
            gain_reg      <= wlfo_pkg::GAIN_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                wlfo_pkg::REG_PHASE_INC: phase_inc_reg <= cfg_data[wlfo_pkg::INC_BITS-1:0];
                wlfo_pkg::REG_WAVE_SEL:  wave_sel_reg  <= cfg_data[wlfo_pkg::SEL_BITS-1:0];
                wlfo_pkg::REG_UNIPOLAR:  unipolar_reg  <= cfg_data[0];
                wlfo_pkg::REG_GAIN:      gain_reg      <= cfg_data[GB-1:0];
                default:                 ;
            endcase
        end
    end

    // Phase split; the entry after the last wraps to entry 0
    assign idx       = phase_reg[PHB-1:FB];
    assign nxt       = idx + TB'(1);
    assign frac      = phase_reg[FB-1:0];
    assign phase_sum = PSB'(phase_reg) + PSB'(phase_inc_reg);

    // Advance the phase modulo the table length once the fraction is used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (cmd.load_interp)
        begin
            phase_reg <= phase_sum[PHB-1:0];
        end
    end

    // Sine table, registered read
    assign rom_addr = sine_fold(cmd.addr_next ? nxt : idx);

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_addr];
    end

    // Entries at the phase index and the next one
    assign entry_index = cmd.load_second ? nxt : idx;
    assign entry       = shape_entry(wave_sel_reg, entry_index, rom_q_reg);

    // Linear interpolation: y1 + round((y2 - y1) * f / 2^F), ties up
    assign diff        = DB'(y2_reg) - DB'(y1_reg);
    assign prod        = PB'(diff) * PB'($signed({1'b0, frac}));
    assign prod_shift  = (prod + INT_HALF) >>> FB;
    assign interp_next = EB'(prod_shift[DB-1:0] + DB'(y1_reg));

    // Unipolar map, gain with rounding, saturation
    assign uni_sum    = DB'(interp_reg) + ONE_S_D;
    assign mapped     = unipolar_reg ? EB'(uni_sum >>> 1) : interp_reg;
    assign gain_prod  = GPB'(mapped) * GPB'($signed({1'b0, gain_reg}));
    assign gain_shift = (gain_prod + G_HALF) >>> GFB;

    always_comb
    begin
        if (gain_shift > SAT_HI)
        begin
            result_next = SAT_HI[SB-1:0];
        end
        else if (gain_shift < SAT_LO)
        begin
            result_next = SAT_LO[SB-1:0];
        end
        else
        begin
            result_next = gain_shift[SB-1:0];
        end
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_first)
        begin
            y1_reg <= entry;
        end
        if (cmd.load_second)
        begin
            y2_reg <= entry;
        end
        if (cmd.load_interp)
        begin
            interp_reg <= interp_next;
        end
        if (cmd.load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: sv/wavetable_lfo_unit.sv
// Wavetable LFO top level: ties the sequencer and the datapath to the
// channels and the configuration port. Uses wlfo_pkg, wlfo_ctrl, wlfo_datapath.
//
//   Channel   Dir   Handshake      Payload
//   tick      in    valid/ready    sample_tick (1)
//   result    out   valid/ready    lfo_value (16, signed, Q1.15)
//   cfg_*     in    cfg_wen only   cfg_index (2), cfg_data (32)
//
// A tick with sample_tick high goes from accept to result through the
// accept cycle, two sine table reads through its single registered port,
// the interpolation multiply, then the gain multiply into the result register.
// A tick with sample_tick low is accepted when idle, gives no result and
// holds the phase. Reset clears the phase and loads the register defaults.
// A stalled result holds in its register; the next tick is taken meanwhile,
// and waits in its last step only if the earlier result is still not taken.
module wavetable_lfo_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    wlfo_tick_if.sink                           tick,
    wlfo_value_if.source                        result,
    input  logic                                cfg_wen,
    input  logic [wlfo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wlfo_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    wlfo_pkg::wlfo_cmd_t cmd;
    logic                tick_ready;
    logic                result_valid;
    logic signed [wlfo_pkg::SAMPLE_BITS-1:0] result_value;

    // Sequencer
    wlfo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_tick   (tick.sample_tick),
        .in_ready  (tick_ready),
        .out_valid (result_valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // Datapath
    wlfo_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .result    (result_value)
    );

    assign tick.ready       = tick_ready;
    assign result.valid     = result_valid;
    assign result.lfo_value = result_value;

endmodule

// File: tb/sv/wavetable_lfo_unit_test.sv
// Self-checking testbench for the wavetable LFO: directed table, then random
// settings and tick requests, each result compared with a typed-in value or a local predictor.
// Depends on wlfo_pkg, wlfo_tick_if, wlfo_value_if and wavetable_lfo_unit.
`timescale 1ns / 100ps

module wavetable_lfo_unit_test;

    import wlfo_pkg::*;

    localparam int     HIGH_NS      = 6;
    localparam int     LOW_NS       = 6;
    localparam int     RESET_CYCLES = 11;
    localparam int     DRAIN_CYCLES = 10;
    localparam int     IDLE_PCT     = 21;
    localparam int     RANDOM_TICKS = 1550;
    localparam int     TIMEOUT_NS   = 8_000_000;

    localparam longint FULL_SCALE   = longint'(1) << (SAMPLE_BITS - 1);
    localparam longint FRAC_ONE     = longint'(1) << PHASE_FRAC_BITS;
    localparam longint GAIN_HALF    = longint'(1) << (GAIN_FRAC_BITS - 1);
    localparam longint TABLE_N      = longint'(TABLE_SIZE);
    localparam logic [63:0] RAD_PER_TURN_Q30 = 64'd6746518852;

    localparam int     NUM_REGS     = 1 << CFG_INDEX_BITS;
    localparam int     PLAN_ROWS    = 24;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] inc;
        logic [CFG_DATA_BITS-1:0] wave;
        logic [CFG_DATA_BITS-1:0] uni;
        logic [CFG_DATA_BITS-1:0] gain;
        logic                     tick;
        logic                     known;
        logic [SAMPLE_BITS-1:0]   want;
    } plan_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wen;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;

    wlfo_tick_if  tick_ch ();
    wlfo_value_if result_ch ();

    // Predictor state: phase and the register copies
    logic [PHASE_BITS-1:0]      phase_acc = '0;
    logic [INC_BITS-1:0]        step_inc  = '0;
    logic [SEL_BITS-1:0]        wave_sel  = WAVE_SEL_RESET;
    logic                       unipolar  = 1'b0;
    logic [GAIN_BITS-1:0]       gain      = GAIN_RESET;

    // Raw values last written, to spot which registers a table row changes
    logic [CFG_DATA_BITS-1:0]   raw_inc   = '0;
    logic [CFG_DATA_BITS-1:0]   raw_wave  = CFG_DATA_BITS'(WAVE_SEL_RESET);
    logic [CFG_DATA_BITS-1:0]   raw_uni   = '0;
    logic [CFG_DATA_BITS-1:0]   raw_gain  = CFG_DATA_BITS'(GAIN_RESET);

    logic [SAMPLE_BITS-1:0]     pending_samples [$];
    logic                       quiet = 1'b0;
    int                         mismatches = 0;
    int                         samples_checked = 0;
    int                         reg_writes = 0;
    int                         settings_used = 0;

    // Directed requests; expected values typed in only at phase zero
    plan_row_t plan [PLAN_ROWS] = '{
        '{32'h0, WAVE_SINE,     32'h0, 32'd16384, 1'b1, 1'b1, 16'h0000},
        '{32'h0, WAVE_SINE,     32'h0, 32'd16384, 1'b0, 1'b0, 16'h0000},
        '{32'h0, WAVE_SAW,      32'h0, 32'd16384, 1'b1, 1'b1, 16'h8000},
        '{32'h0, WAVE_TRIANGLE, 32'h0, 32'd16384, 1'b1, 1'b1, 16'h8000},
        '{32'h0, WAVE_PULSE,    32'h0, 32'd16384, 1'b1, 1'b1, 16'h7FFF},
        '{32'h0, WAVE_PULSE,    32'h0, 32'd0,     1'b1, 1'b1, 16'h0000},
        '{32'h0, WAVE_PULSE,    32'h0, 32'd65535, 1'b1, 1'b1, 16'h7FFF},
        '{32'h0, WAVE_SAW,      32'h0, 32'd65535, 1'b1, 1'b1, 16'h8000},
        '{32'h0, WAVE_SAW,      32'h1, 32'd16384, 1'b1, 1'b1, 16'h0000},
        '{32'h0, WAVE_PULSE,    32'h1, 32'd16384, 1'b1, 1'b1, 16'h7FFF},
        '{32'h0, WAVE_SINE,     32'h1, 32'd16384, 1'b1, 1'b1, 16'h4000},
        '{32'h0020_0000, WAVE_SAW,      32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'h0020_0000, WAVE_SAW,      32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'h0010_0000, WAVE_TRIANGLE, 32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'h0010_0000, WAVE_TRIANGLE, 32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'h0010_0000, WAVE_TRIANGLE, 32'h0, 32'd16384, 1'b0, 1'b0, 16'h0},
        '{32'h0010_0000, WAVE_TRIANGLE, 32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'hFFFF_FFFF, WAVE_SINE,     32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'hFFFF_FFFF, WAVE_SINE,     32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'h8000_0000, WAVE_PULSE,    32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'h8000_0000, WAVE_PULSE,    32'h0, 32'd16384, 1'b1, 1'b0, 16'h0},
        '{32'h0030_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'h0001_C000, 1'b1, 1'b0, 16'h0},
        '{32'h1234_5679, 32'h7FFF_FFFD, 32'hFFFF_FFFF, 32'hABCD_2000, 1'b1, 1'b0, 16'h0},
        '{32'h1234_5679, 32'h7FFF_FFFD, 32'hFFFF_FFFF, 32'hABCD_2000, 1'b1, 1'b0, 16'h0}
    };

    wavetable_lfo_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HIGH_NS clk = 1'b1;
        #LOW_NS  clk = 1'b0;
    end

    // Sine entry: fold to a quarter wave, then Q30 Taylor series to x^15
    function automatic longint sine_point(int unsigned i);
        logic [63:0] turns;
        logic [63:0] rad;
        logic [63:0] rad_sq;
        logic [63:0] term;
        logic [63:0] mag;
        longint      total;
        logic        negative;
        turns    = (64'(i) << 32) / 64'(TABLE_SIZE);
        negative = 1'b0;
        if (turns >= 64'h8000_0000)
        begin
            negative = 1'b1;
            turns    = turns - 64'h8000_0000;
        end
        if (turns > 64'h4000_0000)
        begin
            turns = 64'h8000_0000 - turns;
        end
        rad    = (turns * RAD_PER_TURN_Q30) >> 32;
        rad_sq = (rad * rad) >> 30;
        term   = rad;
        total  = longint'(rad);
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * rad_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                total = total - longint'(term);
            end
            else
            begin
                total = total + longint'(term);
            end
        end
        if (total < 0)
        begin
            total = 0;
        end
        mag = (64'(total) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
        return negative ? -longint'(mag) : longint'(mag);
    endfunction

    // Table entry i of the selected shape, in [-S, S]
    function automatic longint wave_point(logic [SEL_BITS-1:0] sel, int unsigned i);
        longint pos;
        pos = longint'(i);
        case (sel)
            WAVE_SAW:
            begin
                return (2 * pos * FULL_SCALE) / TABLE_N - FULL_SCALE;
            end
            WAVE_SINE:
            begin
                return sine_point(i);
            end
            WAVE_TRIANGLE:
            begin
                if (i <= TABLE_SIZE / 2)
                begin
                    return (4 * pos * FULL_SCALE) / TABLE_N - FULL_SCALE;
                end
                return 3 * FULL_SCALE - (4 * pos * FULL_SCALE) / TABLE_N;
            end
            default:
            begin
                // pulse: high up to and including the midpoint
                return (i <= TABLE_SIZE / 2) ? FULL_SCALE : 0;
            end
        endcase
    endfunction

    // Produce the next LFO sample and advance the phase
    function automatic logic [SAMPLE_BITS-1:0] predict_lfo_sample();
        int unsigned idx;
        int unsigned nxt;
        longint      frac;
        longint      y1;
        longint      y2;
        longint      acc;
        longint      y;
        idx  = phase_acc >> PHASE_FRAC_BITS;
        nxt  = (idx + 1 == TABLE_SIZE) ? 0 : idx + 1;
        frac = longint'(phase_acc[PHASE_FRAC_BITS-1:0]);
        y1   = wave_point(wave_sel, idx);
        y2   = wave_point(wave_sel, nxt);

        // interpolate on an offset scale, ties round up
        acc = (y1 + FULL_SCALE) * (FRAC_ONE - frac) + (y2 + FULL_SCALE) * frac;
        acc = acc + (FRAC_ONE >>> 1);
        y   = (acc >>> PHASE_FRAC_BITS) - FULL_SCALE;

        // phase range is exactly the accumulator width, so the wrap is free
        phase_acc = PHASE_BITS'(phase_acc + step_inc);

        if (unipolar)
        begin
            y = (y + FULL_SCALE) >>> 1;
        end
        y = (y * longint'(gain) + GAIN_HALF) >>> GAIN_FRAC_BITS;

        if (y < -FULL_SCALE)
        begin
            y = -FULL_SCALE;
        end
        if (y > FULL_SCALE - 1)
        begin
            y = FULL_SCALE - 1;
        end
        return SAMPLE_BITS'(y);
    endfunction

    task automatic report_mismatch(input string what, input logic [SAMPLE_BITS-1:0] got,
                                   input logic [SAMPLE_BITS-1:0] want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, $signed(got), $signed(want));
        mismatches++;
    endtask

    // Drive one register write; the block takes it at the next rising edge
    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        reg_writes++;
        case (index)
            REG_PHASE_INC:
            begin
                step_inc = value[INC_BITS-1:0];
                raw_inc  = value;
            end
            REG_WAVE_SEL:
            begin
                wave_sel = value[SEL_BITS-1:0];
                raw_wave = value;
            end
            REG_UNIPOLAR:
            begin
                unipolar = value[0];
                raw_uni  = value;
            end
            REG_GAIN:
            begin
                gain     = value[GAIN_BITS-1:0];
                raw_gain = value;
            end
            default:
            begin
            end
        endcase
    endtask

    // Write the selected registers back to back, then drop the enable
    task automatic load_settings(input logic [NUM_REGS-1:0] which,
                                 input logic [CFG_DATA_BITS-1:0] inc_v,
                                 input logic [CFG_DATA_BITS-1:0] wave_v,
                                 input logic [CFG_DATA_BITS-1:0] uni_v,
                                 input logic [CFG_DATA_BITS-1:0] gain_v);
        if (which[REG_PHASE_INC])
        begin
            put_reg(REG_PHASE_INC, inc_v);
        end
        if (which[REG_WAVE_SEL])
        begin
            put_reg(REG_WAVE_SEL, wave_v);
        end
        if (which[REG_UNIPOLAR])
        begin
            put_reg(REG_UNIPOLAR, uni_v);
        end
        if (which[REG_GAIN])
        begin
            put_reg(REG_GAIN, gain_v);
        end
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    // Drop the tick request and wait until the block has gone quiet
    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Offer one tick request, with a random hold-off outside the quiet stretch
    task automatic send_tick(input logic tick_bit, input logic known,
                             input logic [SAMPLE_BITS-1:0] want);
        logic [SAMPLE_BITS-1:0] predicted;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.sample_tick <= tick_bit;
        @(posedge clk);
        while (!tick_ch.ready)
        begin
            @(posedge clk);
        end
        // a low tick holds the phase and produces nothing
        if (tick_bit)
        begin
            predicted = predict_lfo_sample();
            pending_samples.push_back(known ? want : predicted);
        end
        @(negedge clk);
    endtask

    // Stall the result side at random
    always @(negedge clk)
    begin
        result_ch.ready <= (!quiet && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
    end

    // Compare each accepted result with the oldest pending sample
    always @(posedge clk)
    begin : check_results
        logic [SAMPLE_BITS-1:0] want_value;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                report_mismatch("result with no request pending", result_ch.lfo_value, '0);
            end
            else
            begin
                want_value = pending_samples.pop_front();
                samples_checked++;
                if (result_ch.lfo_value !== want_value)
                begin
                    report_mismatch("lfo_value", result_ch.lfo_value, want_value);
                end
            end
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("timeout with %0d samples pending", pending_samples.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        logic [NUM_REGS-1:0]      dirty;
        logic [CFG_DATA_BITS-1:0] r_inc;
        logic [CFG_DATA_BITS-1:0] r_wave;
        logic [CFG_DATA_BITS-1:0] r_uni;
        logic [CFG_DATA_BITS-1:0] r_gain;
        logic [GAIN_BITS-1:0]     g;
        logic                     tick_bit;
        int                       burst;
        int                       random_ticks;

        rst_n               = 1'b0;
        cfg_wen             = 1'b0;
        cfg_index           = REG_PHASE_INC;
        cfg_data            = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.sample_tick = 1'b0;
        result_ch.ready     = 1'b0;
        random_ticks        = 0;

        repeat (RESET_CYCLES)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table, writing only the registers a row changes
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            dirty                = '0;
            dirty[REG_PHASE_INC] = (plan[r].inc  != raw_inc);
            dirty[REG_WAVE_SEL]  = (plan[r].wave != raw_wave);
            dirty[REG_UNIPOLAR]  = (plan[r].uni  != raw_uni);
            dirty[REG_GAIN]      = (plan[r].gain != raw_gain);
            if (dirty != '0)
            begin
                settle();
                load_settings(dirty, plan[r].inc, plan[r].wave, plan[r].uni, plan[r].gain);
            end
            send_tick(plan[r].tick, plan[r].known, plan[r].want);
        end

        // Random settings, each followed by a burst of tick requests
        while (random_ticks < RANDOM_TICKS)
        begin
            case ($urandom_range(5))
                0:       r_inc = '0;
                1:       r_inc = '1;
                2:       r_inc = $urandom;
                3:       r_inc = $urandom_range(0, 1 << 23);
                4:       r_inc = CFG_DATA_BITS'($urandom_range(0, TABLE_SIZE - 1)) << PHASE_FRAC_BITS;
                default: r_inc = $urandom_range(1, 1 << 16);
            endcase
            case ($urandom_range(5))
                0:       g = '0;
                1:       g = '1;
                2:       g = GAIN_RESET;
                default: g = GAIN_BITS'($urandom);
            endcase
            r_gain = {16'($urandom), g};
            r_wave = {30'($urandom), SEL_BITS'($urandom_range(3))};
            r_uni  = $urandom;
            dirty  = (random_ticks == 0) ? '1 : NUM_REGS'($urandom_range(1, (1 << NUM_REGS) - 1));
            settle();
            load_settings(dirty, r_inc, r_wave, r_uni, r_gain);

            burst = $urandom_range(20, 90);
            repeat (burst)
            begin
                quiet    = (random_ticks >= 600 && random_ticks < 850);
                tick_bit = ($urandom_range(99) >= 8);
                send_tick(tick_bit, 1'b0, '0);
                random_ticks++;
            end
        end
        quiet = 1'b0;

        settle();
        $display("covered %0d settings over %0d register writes, all shapes and modes",
                 settings_used, reg_writes);
        $display("checked %0d samples, %0d mismatches", samples_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
